>>> src/tls_pkg.sv
package tls_pkg;

	// Per-logit control flags, set by the front end when the logit is accepted.
	typedef struct packed {
		logic first;   // first logit of a row
		logic last;    // last logit of a row
		logic hit;     // this position is the target
		logic bad;     // held target is outside the row (valid on last)
	} tls_flags_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP1,
		ST_EXP2,
		ST_EXP3,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_UPD,
		ST_NORM,
		ST_SQ,
		ST_LN1,
		ST_LN2
	} tls_state_t;

	localparam int SUM_W = 34;
	localparam int LEN_W = 18;
	localparam int TGT_W = 17;
	localparam int OUT_W = 24;
	localparam logic [LEN_W-1:0] ROW_LEN_RST = 18'd131072;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] LN2_Q16 = 16'd45426;

	// 2^(-i/16) in Q.16
	function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

>>> src/tls_front.sv
module tls_front #(
	parameter int VOCAB_MAX  = 131072
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [tls_pkg::TGT_W-1:0]    target_index,
	input  logic [$clog2(VOCAB_MAX+1)-1:0] eff_len,
	output tls_pkg::tls_flags_t          flags
);
	import tls_pkg::*;

	localparam int PW = $clog2(VOCAB_MAX + 1);
	localparam int CW = (PW > TGT_W) ? PW : TGT_W;

	logic [PW-1:0]    pos_q;
	logic [TGT_W-1:0] held_q;
	logic [TGT_W-1:0] held_eff;
	logic [PW-1:0]    pos_inc;

	assign held_eff = (pos_q == '0) ? target_index : held_q;
	assign pos_inc  = pos_q + PW'(1);

	always_comb begin
		flags.first = (pos_q == '0);
		flags.last  = (pos_inc >= eff_len);
		flags.hit   = (CW'(pos_q) == CW'(held_eff));
		flags.bad   = (CW'(held_eff) >= CW'(eff_len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			held_q <= '0;
		end else if (push) begin
			held_q <= held_eff;
			pos_q  <= flags.last ? '0 : pos_inc;
		end
	end

endmodule

>>> src/tls_queue.sv
module tls_queue #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         nempty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign rdata  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> src/tls_back.sv
module tls_back #(
	parameter int LOGIT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nempty,
	input  logic signed [LOGIT_BITS-1:0]  q_logit,
	input  tls_pkg::tls_flags_t           q_flags,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [tls_pkg::OUT_W-1:0] logprob,
	output logic                          bad_target
);
	import tls_pkg::*;

	localparam int LB = LOGIT_BITS;
	localparam int TW = (LB + 1 > 13) ? LB + 1 : 13;
	localparam int VW = (LB + 3 > 26) ? LB + 3 : 26;

	tls_state_t state_q, state_d;

	logic signed [LB-1:0] x_q, max_q, tv_q;
	tls_flags_t           fl_q;
	logic                 gt_q, big_q, kill_q;
	logic [TW-1:0]        t_q;
	logic [20:0]          y_q;
	logic [16:0]          m_q, e_q;
	logic [4:0]           k_q;
	logic [SUM_W-1:0]     sum_q, w_q;
	logic [33:0]          lo_q;
	logic [50:0]          prod_q;
	logic [5:0]           p_q;
	logic [30:0]          mn_q;
	logic [4:0]           cnt_q;
	logic [15:0]          frac_q;
	logic [36:0]          lnp_q;
	logic                 out_valid_q, bad_q;
	logic signed [OUT_W-1:0] logprob_q;

	// combinational datapath
	logic signed [LB:0]   diff;
	logic                 gt_now;
	logic [TW-1:0]        t_now;
	logic [28:0]          yp;
	logic [16:0]          ta, tb, m_now;
	logic [23:0]          interp;
	logic [4:0]           k_now;
	logic                 kill_now;
	logic [17:0]          m_rnd;
	logic [16:0]          e_now;
	logic [50:0]          resc;
	logic [35:0]          resc_sum;
	logic [34:0]          add_sum;
	logic [SUM_W-1:0]     new_sum;
	logic [61:0]          sq;
	logic [31:0]          sq_s;
	logic [20:0]          l2;
	logic [13:0]          ln_v;
	logic signed [VW-1:0] v;
	logic signed [OUT_W-1:0] v_sat;
	logic                 load_out;

	always_comb begin
		diff   = $signed({q_logit[LB-1], q_logit}) - $signed({max_q[LB-1], max_q});
		gt_now = (q_logit > max_q);
		t_now  = TW'(gt_now ? diff : -diff);

		yp = t_q[11:0] * LOG2E_Q16;

		k_now    = y_q[20:16];
		kill_now = big_q || (k_now > 5'd16);
		ta       = pow2_tab({1'b0, y_q[15:12]});
		tb       = pow2_tab({1'b0, y_q[15:12]} + 5'd1);
		interp   = ((ta - tb) * y_q[11:0]) + 24'd2048;
		m_now    = ta - 17'(interp[23:12]);

		m_rnd = 18'(m_q) + (18'd1 << (k_q - 5'd1));
		if (kill_q) begin
			e_now = '0;
		end else if (k_q == 5'd0) begin
			e_now = m_q;
		end else begin
			e_now = 17'(m_rnd >> k_q);
		end

		resc     = (prod_q + 51'd32768) >> 16;
		resc_sum = 36'(resc) + 36'(ONE_Q16);
		add_sum  = 35'(sum_q) + 35'(e_q);
		if (gt_q) begin
			new_sum = (resc_sum > 36'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : SUM_W'(resc_sum);
		end else begin
			new_sum = add_sum[34] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];
		end

		sq   = mn_q * mn_q;
		sq_s = sq[61:30];

		l2   = {5'(p_q - 6'd16), frac_q};
		ln_v = 14'((lnp_q + 37'd8388608) >> 24);

		v = VW'(tv_q) - VW'(max_q) - $signed({{(VW-14){1'b0}}, ln_v});
		if (v > 0) begin
			v_sat = '0;
		end else if (v < -$signed(VW'(24'h800000))) begin
			v_sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			v_sat = v[OUT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_nempty) begin
					pop = 1'b1;
					if (q_flags.first) begin
						state_d = q_flags.last ? ST_NORM : ST_IDLE;
					end else begin
						state_d = ST_EXP1;
					end
				end
			end
			ST_EXP1:   state_d = ST_EXP2;
			ST_EXP2:   state_d = ST_EXP3;
			ST_EXP3:   state_d = gt_q ? ST_MUL_LO : ST_UPD;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_UPD;
			ST_UPD:    state_d = fl_q.last ? ST_NORM : ST_IDLE;
			ST_NORM:   state_d = w_q[SUM_W-1] ? ST_SQ : ST_NORM;
			ST_SQ:     state_d = (cnt_q == 5'd15) ? ST_LN1 : ST_SQ;
			ST_LN1:    state_d = ST_LN2;
			ST_LN2: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q  <= q_logit;
			fl_q <= q_flags;
			gt_q <= gt_now;
			t_q  <= t_now;
			if (q_flags.first) begin
				max_q <= q_logit;
				sum_q <= SUM_W'(ONE_Q16);
				tv_q  <= q_flags.hit ? q_logit : '0;
				w_q   <= SUM_W'(ONE_Q16);
				p_q   <= 6'd33;
			end
		end
		if (state_q == ST_EXP1) begin
			y_q   <= yp[28:8];
			big_q <= (t_q[TW-1:12] != '0);
		end
		if (state_q == ST_EXP2) begin
			m_q    <= m_now;
			k_q    <= k_now;
			kill_q <= kill_now;
		end
		if (state_q == ST_EXP3) e_q <= e_now;
		if (state_q == ST_MUL_LO) lo_q <= sum_q[16:0] * e_q;
		if (state_q == ST_MUL_HI)
			prod_q <= (51'(34'(sum_q[33:17]) * 34'(e_q)) << 17) + 51'(lo_q);
		if (state_q == ST_UPD) begin
			sum_q <= new_sum;
			if (gt_q) max_q <= x_q;
			if (fl_q.hit) tv_q <= x_q;
			w_q <= (new_sum < SUM_W'(ONE_Q16)) ? SUM_W'(ONE_Q16) : new_sum;
			p_q <= 6'd33;
		end
		if (state_q == ST_NORM) begin
			if (w_q[SUM_W-1]) begin
				mn_q   <= w_q[33:3];
				cnt_q  <= '0;
				frac_q <= '0;
			end else begin
				w_q <= w_q << 1;
				p_q <= p_q - 6'd1;
			end
		end
		if (state_q == ST_SQ) begin
			mn_q   <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
			frac_q <= {frac_q[14:0], sq_s[31]};
			cnt_q  <= cnt_q + 5'd1;
		end
		if (state_q == ST_LN1) lnp_q <= 37'(l2) * 37'(LN2_Q16);
		if (load_out) begin
			bad_q     <= fl_q.bad;
			logprob_q <= fl_q.bad ? '0 : v_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign logprob    = logprob_q;
	assign bad_target = bad_q;

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ |-> mn_q[30]) else $error("squaring operand not normalized");
	a_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (logprob_q[OUT_W-1] || logprob_q == '0)) else $error("positive logprob");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> logprob_q == '0) else $error("bad target with nonzero result");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q) else $error("result lost on load");

endmodule

>>> src/token_log_softmax.sv
// token_log_softmax: log-probability of one target token over a row of logits.
// Input channel (in_valid/in_stall): one request per logit, signed Q7.8, plus
//   target_index, which is sampled only on the first logit of a row.
// Output channel (out_valid/out_stall): one request per row, after its last
//   logit: logprob (signed Q15.8, saturated to -2^23..0) and bad_target.
//   bad_target=1 means the target was not below the row length; logprob is 0.
// Config: cfg_wr_en/cfg_wr_data write row_length (0 acts as 1, above
//   VOCAB_MAX acts as VOCAB_MAX). Write only while idle.
// Back end: a row's first logit is taken in idle alone; one not above the
//   running max goes through exp lookup/interpolation and the sum update, one
//   that raises it also a two-step 34x17 rescale multiply. A new logit is
//   popped only in idle; the front end and a 2-entry queue absorb bursts.
// Result: after the last logit, the log unit normalizes the sum, squares it to
//   extract the 16 fraction bits, scales by ln 2, then registers the result.
// Reset clears the row position, the queue and the result valid flag; row_length
//   returns to 131072. A stalled result holds; the back end waits for the
//   output register while the front end keeps filling the queue.
module token_log_softmax #(
	parameter int VOCAB_MAX  = 131072,
	parameter int LOGIT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [LOGIT_BITS-1:0]     logit,
	input  logic [tls_pkg::TGT_W-1:0]        target_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [tls_pkg::OUT_W-1:0] logprob,
	output logic                             bad_target,
	input  logic                             cfg_wr_en,
	input  logic [tls_pkg::LEN_W-1:0]        cfg_wr_data
);
	import tls_pkg::*;

	localparam int PW = $clog2(VOCAB_MAX + 1);
	localparam int CW = (PW > LEN_W) ? PW : LEN_W;
	localparam int QW = LOGIT_BITS + $bits(tls_flags_t);

	logic [LEN_W-1:0] row_len_q;
	logic [PW-1:0]    eff_len;
	logic             push, pop, q_full, q_nempty;
	tls_flags_t       in_flags, q_flags;
	logic [QW-1:0]    q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= ROW_LEN_RST;
		end else if (cfg_wr_en) begin
			row_len_q <= cfg_wr_data;
		end
	end

	// clamp the programmed length to 1..VOCAB_MAX
	always_comb begin
		if (row_len_q == '0) begin
			eff_len = PW'(1);
		end else if (CW'(row_len_q) > CW'(VOCAB_MAX)) begin
			eff_len = PW'(VOCAB_MAX);
		end else begin
			eff_len = PW'(row_len_q);
		end
	end

	assign push     = in_valid && !q_full;
	assign in_stall = q_full;

	tls_front #(.VOCAB_MAX(VOCAB_MAX)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.target_index (target_index),
		.eff_len      (eff_len),
		.flags        (in_flags)
	);

	tls_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({logit, in_flags}),
		.pop    (pop),
		.full   (q_full),
		.nempty (q_nempty),
		.rdata  (q_rdata)
	);

	assign q_flags = q_rdata[$bits(tls_flags_t)-1:0];

	tls_back #(.LOGIT_BITS(LOGIT_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nempty   (q_nempty),
		.q_logit    ($signed(q_rdata[QW-1:$bits(tls_flags_t)])),
		.q_flags    (q_flags),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.logprob    (logprob),
		.bad_target (bad_target)
	);

endmodule
